/* design/spfq_pkg.sv */
// shared types and constants for the three-level strict priority fifo
// no dependencies; imported by spfq_ctrl, spfq_dp and the top level
package spfq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int ID_WIDTH    = 16;
  localparam int NUM_LEVELS  = 3;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_W   = $clog2(NUM_LEVELS);
  localparam int STORE_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);

  localparam int CMD_W   = 1;
  localparam int PID_W   = 16;
  localparam int SEV_W   = 2;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 8;
  localparam int TOTAL_W = 32;

  localparam logic [CMD_W-1:0] CMD_ARRIVE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SERVE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_QUEUED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_BADLEVEL = 3'd2,
    ST_SERVED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic capture;
    logic load_out;
  } spfq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic serve_hit;
    logic out_free;
  } spfq_stat_t;

endpackage

/* design/spfq_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
module spfq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/spfq_ctrl.sv */
// sequencing state machine for the priority fifo
// depends on spfq_pkg
module spfq_ctrl
  import spfq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  spfq_stat_t st,
  output spfq_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = st.serve_hit ? S_READ : S_DONE;
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/spfq_dp.sv */
// datapath: queue pointers, occupancies, serve counter, entry store, result register
// depends on spfq_pkg and spfq_ram
module spfq_dp
  import spfq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  spfq_cmd_t           cmd,
  output spfq_stat_t          st,
  input  logic [CMD_W-1:0]    command,
  input  logic [PID_W-1:0]    patient_id,
  input  logic [SEV_W-1:0]    severity,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [STAT_W-1:0]   status,
  output logic [PID_W-1:0]    served_id,
  output logic [SEV_W-1:0]    served_level,
  output logic [COUNT_W-1:0]  count_high,
  output logic [COUNT_W-1:0]  count_mid,
  output logic [COUNT_W-1:0]  count_low,
  output logic [TOTAL_W-1:0]  served_total
);

  // latched item
  logic [CMD_W-1:0]    cmd_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [SEV_W-1:0]    sev_r;

  // queue state
  logic [PTR_W-1:0]    head [NUM_LEVELS];
  logic [PTR_W-1:0]    tail [NUM_LEVELS];
  logic [OCC_W-1:0]    occ  [NUM_LEVELS];
  logic [TOTAL_W-1:0]  total;

  // per-item result
  status_t             stat_r;
  logic [SEV_W-1:0]    slevel_r;
  logic [ID_WIDTH-1:0] sid_r;

  // selection
  logic [LVL_W-1:0]    arr_q;
  logic [LVL_W-1:0]    srv_q;
  logic                srv_hit;
  logic                arr_full;
  logic                do_write;
  logic                do_read;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic [ID_WIDTH-1:0] rdata;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    advance = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [LVL_W-1:0] q,
                                                   input logic [PTR_W-1:0] p);
    entry_addr = ADDR_W'(ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(p);
  endfunction

  assign arr_q    = LVL_W'(sev_r - SEV_W'(1));
  assign arr_full = (occ[arr_q] == OCC_W'(QUEUE_DEPTH));

  // highest-priority non-empty queue
  always_comb begin
    srv_q   = '0;
    srv_hit = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (occ[i] != '0) begin
        srv_q   = LVL_W'(i);
        srv_hit = 1'b1;
      end
    end
  end

  assign do_write = cmd.exec && (cmd_r == CMD_ARRIVE) && (sev_r != '0) && !arr_full;
  assign do_read  = cmd.exec && (cmd_r == CMD_SERVE) && srv_hit;
  assign waddr    = entry_addr(arr_q, tail[arr_q]);
  assign raddr    = entry_addr(srv_q, head[srv_q]);

  assign st.serve_hit = (cmd_r == CMD_SERVE) && srv_hit;
  assign st.out_free  = !rsp_valid || rsp_ready;

  spfq_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (waddr),
    .wdata (id_r),
    .re    (do_read),
    .raddr (raddr),
    .rdata (rdata)
  );

  // item capture and result fields
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= command;
      id_r  <= ID_WIDTH'(patient_id);
      sev_r <= severity;
    end
    if (cmd.exec) begin
      sid_r    <= '0;
      slevel_r <= '0;
      if (cmd_r == CMD_ARRIVE) begin
        if (sev_r == '0) begin
          stat_r <= ST_BADLEVEL;
        end else if (arr_full) begin
          stat_r <= ST_DROPPED;
        end else begin
          stat_r <= ST_QUEUED;
        end
      end else if (srv_hit) begin
        stat_r   <= ST_SERVED;
        slevel_r <= SEV_W'(srv_q) + SEV_W'(1);
      end else begin
        stat_r <= ST_EMPTY;
      end
    end
    if (cmd.capture) begin
      sid_r <= rdata;
    end
  end

  // queue pointers, occupancies and serve counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        occ[i]  <= '0;
      end
      total <= '0;
    end else begin
      if (do_write) begin
        tail[arr_q] <= advance(tail[arr_q]);
        occ[arr_q]  <= occ[arr_q] + OCC_W'(1);
      end
      if (do_read) begin
        head[srv_q] <= advance(head[srv_q]);
        occ[srv_q]  <= occ[srv_q] - OCC_W'(1);
        if (total != '1) begin
          total <= total + TOTAL_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= stat_r;
      served_id    <= PID_W'(sid_r);
      served_level <= slevel_r;
      count_high   <= COUNT_W'(occ[0]);
      count_mid    <= COUNT_W'(occ[1]);
      count_low    <= COUNT_W'(occ[2]);
      served_total <= total;
    end
  end

endmodule

/* design/three_level_strict_priority_fifo.sv */
// top level of the three-level strict priority fifo
// depends on spfq_pkg, spfq_ctrl, spfq_dp (which holds spfq_ram)
//
// Three circular fifo queues of identifiers, one per level (1 highest, 3
// lowest), share one entry store of 3 x 128 words. An arrive item
// (command 0) appends patient_id to the queue picked by severity; level 0
// is reported as a bad level, and an arrival to a full queue is dropped
// and flagged. A serve item (command 1) pops the oldest entry of the
// highest-priority non-empty queue, or reports that nothing waits. Each
// item gives exactly one result with the status, the served identifier
// and level, the three occupancies after the item and a saturating count
// of successful serves. Items are handled one at a time: an arrive goes
// through the execute and done states from acceptance to result, and a
// serve that finds an entry also passes a read state, for the registered
// read port of the entry store. The result sits in an output register,
// and the next item is accepted while it waits to be taken; a new result
// is loaded only once the old one has gone. No clearing pass is needed
// after reset: entries are read only after they were written.
module three_level_strict_priority_fifo
  import spfq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [CMD_W-1:0]   command,
  input  logic [PID_W-1:0]   patient_id,
  input  logic [SEV_W-1:0]   severity,
  // result channel
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [STAT_W-1:0]  status,
  output logic [PID_W-1:0]   served_id,
  output logic [SEV_W-1:0]   served_level,
  output logic [COUNT_W-1:0] count_high,
  output logic [COUNT_W-1:0] count_mid,
  output logic [COUNT_W-1:0] count_low,
  output logic [TOTAL_W-1:0] served_total
);

  spfq_cmd_t  cmd;
  spfq_stat_t st;

  // controller: accept, execute, wait for store read, hand off result
  spfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: queue state, entry store and result register
  spfq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .command      (command),
    .patient_id   (patient_id),
    .severity     (severity),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .served_id    (served_id),
    .served_level (served_level),
    .count_high   (count_high),
    .count_mid    (count_mid),
    .count_low    (count_low),
    .served_total (served_total)
  );

endmodule
